[hw/rtl/fpcu_pkg.sv]
// shared types, constants and the cordic angle table for the camera update block
package fpcu_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = $clog2(CORDIC_STEPS);

  localparam logic signed [31:0] ANG_90 = 32'sd5898240;
  localparam logic signed [31:0] ANG_180 = 32'sd11796480;
  localparam logic signed [31:0] ANG_360 = 32'sd23592960;
  localparam logic signed [31:0] PITCH_MAX = 32'sd5832704;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;
  localparam logic [32:0] RECIP_TEN = 33'h0_CCCC_CCCD;

  typedef enum logic [1:0] {
    CMD_MOUSE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SENS = 3'd0,
    REG_BASE_SPEED = 3'd1,
    REG_SPRINT_SPEED = 3'd2,
    REG_START_X = 3'd3,
    REG_START_Y = 3'd4,
    REG_START_Z = 3'd5,
    REG_START_YAW = 3'd6,
    REG_START_PITCH = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MMUL, S_MDIV, S_MADD, S_WRAP, S_FOLD, S_CORD,
    S_PROD0, S_PROD1, S_PROD2, S_PROD3, S_PROD4,
    S_KVEL, S_KLOAD, S_KMUL, S_KACC, S_OUT
  } state_t;

  // atan(2^-i) in degrees with 16 fraction bits
  function automatic logic signed [24:0] atan_deg(input logic [4:0] idx);
    logic signed [24:0] r;
    case (idx)
      5'd0: r = 25'sd2949120;
      5'd1: r = 25'sd1740967;
      5'd2: r = 25'sd919879;
      5'd3: r = 25'sd466945;
      5'd4: r = 25'sd234379;
      5'd5: r = 25'sd117304;
      5'd6: r = 25'sd58666;
      5'd7: r = 25'sd29335;
      5'd8: r = 25'sd14668;
      5'd9: r = 25'sd7334;
      5'd10: r = 25'sd3667;
      5'd11: r = 25'sd1833;
      5'd12: r = 25'sd917;
      5'd13: r = 25'sd458;
      5'd14: r = 25'sd229;
      5'd15: r = 25'sd115;
      5'd16: r = 25'sd57;
      5'd17: r = 25'sd29;
      5'd18: r = 25'sd14;
      5'd19: r = 25'sd7;
      5'd20: r = 25'sd4;
      5'd21: r = 25'sd2;
      5'd22: r = 25'sd1;
      default: r = 25'sd0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/first_person_camera_update.sv]
// first person fly camera: angle update, cordic basis and position integration
// order: mouse move scales dx then dy, wraps yaw one step at a time (up to ten),
//   runs the cordic for yaw then pitch and forms the basis; restart enters at the wrap
// throughput: one item at a time; the shared cordic shift-add unit and the single
//   33x33 multiplier serialise the work
// reset: synchronous; registers and camera state return to their defaults
module first_person_camera_update
  import fpcu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // mouse_dx, mouse_dy, delta_time, key_forward, key_left, key_back, key_right,
  // key_rise, key_sink, key_sprint
  input  logic [55:0]  s_axis_tdata,
  // command
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, front_x, front_y, front_z, yaw_out, pitch_out
  output logic [199:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  function automatic logic signed [15:0] clamp14(input logic signed [19:0] v);
    if (v > 20'sd16384) return UNIT_Q14;
    if (v < -20'sd16384) return -UNIT_Q14;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] q30_q14(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = ($signed({v[31], v}) + 33'sd32768) >>> 16;
    return clamp14({{3{t[16]}}, t[16:0]});
  endfunction

  function automatic logic signed [15:0] q60_q14(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = (v + (66'sd1 <<< 45)) >>> 46;
    return clamp14(t[19:0]);
  endfunction

  function automatic logic signed [23:0] clamp_pitch(input logic signed [31:0] v);
    if (v > PITCH_MAX) return PITCH_MAX[23:0];
    if (v < -PITCH_MAX) return 24'(-PITCH_MAX);
    return v[23:0];
  endfunction

  state_t state, state_next;

  logic [15:0] sensitivity, base_speed, sprint_speed;
  logic signed [31:0] start_pos [0:2];
  logic signed [24:0] start_yaw;
  logic signed [23:0] start_pitch;

  logic signed [15:0] dx, dy;
  logic [15:0] dt;
  logic [6:0] keys;
  logic msel, mneg;

  logic signed [31:0] pos [0:2];
  logic signed [24:0] yaw;
  logic signed [23:0] pitch;
  logic signed [15:0] front_v [0:2];
  logic signed [15:0] right_v [0:2];
  logic signed [15:0] up_v [0:2];
  logic sprinting;

  logic signed [31:0] angle_w;
  logic signed [31:0] cx, cyv;
  logic signed [24:0] cz;
  logic [STEP_W-1:0] step;
  logic pass, fold_neg;
  logic signed [31:0] cos_y, sin_y, cos_p, sin_p;

  logic [31:0] vel;
  logic [2:0] key_idx;
  logic [1:0] comp;

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;

  // shared multiplier, one registered product a cycle
  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  logic signed [32:0] p_s;
  logic [32:0] m_abs;
  logic signed [31:0] dq;
  logic signed [16:0] vec_c;
  logic signed [31:0] xs, ys, cx_n, cy_n;
  logic signed [24:0] cz_n, atn;
  logic last_step;
  logic signed [65:0] d_full;
  logic signed [33:0] pos_sum;
  logic signed [31:0] pos_sat;
  logic signed [24:0] fold_a;
  logic fold_n;

  always_comb begin
    p_s = prod[32:0];
    m_abs = (p_s[32] ? 33'(-p_s) : 33'(p_s)) + 33'd5;
    dq = mneg ? -$signed({2'b00, prod[64:35]}) : $signed({2'b00, prod[64:35]});

    vec_c = '0;
    case (key_idx)
      3'd0: vec_c = 17'(front_v[comp]);
      3'd1: vec_c = -17'(right_v[comp]);
      3'd2: vec_c = -17'(front_v[comp]);
      3'd3: vec_c = 17'(right_v[comp]);
      3'd4: vec_c = 17'(up_v[comp]);
      3'd5: vec_c = -17'(up_v[comp]);
      default: vec_c = '0;
    endcase

    // cordic rotation step, shifts round toward minus infinity
    xs = cx >>> step;
    ys = cyv >>> step;
    atn = atan_deg(5'(step));
    if (!cz[24]) begin
      cx_n = cx - ys;
      cy_n = cyv + xs;
      cz_n = cz - atn;
    end else begin
      cx_n = cx + ys;
      cy_n = cyv - xs;
      cz_n = cz + atn;
    end
    last_step = (step == STEP_W'(CORDIC_STEPS - 1));

    d_full = (prod + (66'sd1 <<< 21)) >>> 22;
    pos_sum = 34'(pos[comp]) + d_full[33:0];
    if (pos_sum > 34'sd2147483647) pos_sat = 32'sh7FFFFFFF;
    else if (pos_sum < -34'sd2147483648) pos_sat = 32'sh80000000;
    else pos_sat = pos_sum[31:0];

    // fold yaw into +-90 degrees, results negated afterwards
    fold_n = 1'b0;
    fold_a = yaw;
    if (32'(yaw) > ANG_90) begin
      fold_a = yaw - ANG_180[24:0];
      fold_n = 1'b1;
    end else if (32'(yaw) < -ANG_90) begin
      fold_a = yaw + ANG_180[24:0];
      fold_n = 1'b1;
    end
  end

  // multiplier operand selection
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_MMUL: begin
        op_a = 33'(msel ? dy : dx);
        op_b = {17'd0, sensitivity};
      end
      S_MDIV: begin
        op_a = m_abs;
        op_b = RECIP_TEN;
      end
      S_PROD0: begin
        op_a = 33'(cos_y);
        op_b = 33'(cos_p);
      end
      S_PROD1: begin
        op_a = 33'(sin_y);
        op_b = 33'(cos_p);
      end
      S_PROD2: begin
        op_a = -33'(cos_y);
        op_b = 33'(sin_p);
      end
      S_PROD3: begin
        op_a = -33'(sin_y);
        op_b = 33'(sin_p);
      end
      S_KVEL: begin
        op_a = {17'd0, sprinting ? sprint_speed : base_speed};
        op_b = {17'd0, dt};
      end
      S_KMUL: begin
        op_a = 33'(vec_c);
        op_b = {1'b0, vel};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_axis_tready = (state == S_IDLE);
    m_axis_tvalid = (state == S_OUT);
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            CMD_MOUSE: state_next = S_MMUL;
            CMD_TICK: state_next = S_KVEL;
            CMD_RESTART: state_next = S_WRAP;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_MMUL: state_next = S_MDIV;
      S_MDIV: state_next = S_MADD;
      S_MADD: state_next = msel ? S_WRAP : S_MMUL;
      S_WRAP: begin
        if (angle_w < ANG_180 && angle_w >= -ANG_180) state_next = S_FOLD;
      end
      S_FOLD: state_next = S_CORD;
      S_CORD: begin
        if (last_step && pass) state_next = S_PROD0;
      end
      S_PROD0: state_next = S_PROD1;
      S_PROD1: state_next = S_PROD2;
      S_PROD2: state_next = S_PROD3;
      S_PROD3: state_next = S_PROD4;
      S_PROD4: state_next = S_OUT;
      S_KVEL: state_next = S_KLOAD;
      S_KLOAD: state_next = S_KMUL;
      S_KMUL: state_next = S_KACC;
      S_KACC: begin
        if (comp == 2'd2 && key_idx == 3'd5) state_next = S_OUT;
        else state_next = S_KMUL;
      end
      S_OUT: begin
        if (m_axis_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity <= 16'd6554;
      base_speed <= 16'd1280;
      sprint_speed <= 16'd2560;
      start_pos[0] <= '0;
      start_pos[1] <= '0;
      start_pos[2] <= '0;
      start_yaw <= -ANG_90[24:0];
      start_pitch <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENS: sensitivity <= cfg_data[15:0];
        REG_BASE_SPEED: base_speed <= cfg_data[15:0];
        REG_SPRINT_SPEED: sprint_speed <= cfg_data[15:0];
        REG_START_X: start_pos[0] <= cfg_data;
        REG_START_Y: start_pos[1] <= cfg_data;
        REG_START_Z: start_pos[2] <= cfg_data;
        REG_START_YAW: start_yaw <= cfg_data[24:0];
        REG_START_PITCH: start_pitch <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // camera state and sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0] <= '0;
      pos[1] <= '0;
      pos[2] <= '0;
      yaw <= -ANG_90[24:0];
      pitch <= '0;
      front_v[0] <= '0;
      front_v[1] <= '0;
      front_v[2] <= -UNIT_Q14;
      right_v[0] <= UNIT_Q14;
      right_v[1] <= '0;
      right_v[2] <= '0;
      up_v[0] <= '0;
      up_v[1] <= UNIT_Q14;
      up_v[2] <= '0;
      sprinting <= 1'b0;
      msel <= 1'b0;
      pass <= 1'b0;
      step <= '0;
      key_idx <= '0;
      comp <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            dx <= s_axis_tdata[15:0];
            dy <= s_axis_tdata[31:16];
            dt <= s_axis_tdata[47:32];
            keys <= s_axis_tdata[54:48];
            msel <= 1'b0;
            if (s_axis_tuser == CMD_RESTART) begin
              pos[0] <= start_pos[0];
              pos[1] <= start_pos[1];
              pos[2] <= start_pos[2];
              angle_w <= 32'(start_yaw);
              pitch <= clamp_pitch(32'(start_pitch));
            end
          end
        end
        S_MDIV: mneg <= p_s[32];
        S_MADD: begin
          if (!msel) begin
            angle_w <= 32'(yaw) + dq;
            msel <= 1'b1;
          end else begin
            pitch <= clamp_pitch(32'(pitch) + dq);
          end
        end
        S_WRAP: begin
          if (angle_w >= ANG_180) angle_w <= angle_w - ANG_360;
          else if (angle_w < -ANG_180) angle_w <= angle_w + ANG_360;
          else yaw <= angle_w[24:0];
        end
        S_FOLD: begin
          cx <= CORDIC_GAIN;
          cyv <= '0;
          cz <= fold_a;
          fold_neg <= fold_n;
          step <= '0;
          pass <= 1'b0;
        end
        S_CORD: begin
          if (last_step) begin
            step <= '0;
            cx <= CORDIC_GAIN;
            cyv <= '0;
            cz <= 25'(pitch);
            pass <= 1'b1;
            if (!pass) begin
              cos_y <= fold_neg ? -cx_n : cx_n;
              sin_y <= fold_neg ? -cy_n : cy_n;
            end else begin
              cos_p <= cx_n;
              sin_p <= cy_n;
            end
          end else begin
            step <= step + 1'b1;
            cx <= cx_n;
            cyv <= cy_n;
            cz <= cz_n;
          end
        end
        S_PROD1: front_v[0] <= q60_q14(prod);
        S_PROD2: front_v[2] <= q60_q14(prod);
        S_PROD3: up_v[0] <= q60_q14(prod);
        S_PROD4: begin
          up_v[2] <= q60_q14(prod);
          front_v[1] <= q30_q14(sin_p);
          right_v[0] <= q30_q14(-sin_y);
          right_v[1] <= '0;
          right_v[2] <= q30_q14(cos_y);
          up_v[1] <= q30_q14(cos_p);
        end
        S_KLOAD: begin
          vel <= prod[31:0];
          key_idx <= '0;
          comp <= '0;
        end
        S_KACC: begin
          if (keys[key_idx]) pos[comp] <= pos_sat;
          if (comp == 2'd2) begin
            comp <= '0;
            if (key_idx == 3'd5) sprinting <= keys[6];
            else key_idx <= key_idx + 1'b1;
          end else begin
            comp <= comp + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, pitch, yaw, front_v[2], front_v[1], front_v[0],
                         pos[2], pos[1], pos[0]};

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output sides active together");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    (32'(pitch) <= PITCH_MAX) && (32'(pitch) >= -PITCH_MAX))
    else $error("pitch outside clamp range");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    (32'(yaw) < ANG_180) && (32'(yaw) >= -ANG_180))
    else $error("yaw outside wrap range");

  a_cord_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORD && last_step && pass) |=> (state == S_PROD0))
    else $error("cordic pass did not hand over to products");

endmodule

[sim/tb_first_person_camera_update.sv]
// self-checking testbench for the first person camera update block
`timescale 1ns / 100ps

module tb_first_person_camera_update;
  import fpcu_pkg::*;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [15:0] fx, fy, fz;
    logic [24:0] yaw;
    logic [23:0] pitch;
  } cam_view_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [55:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [199:0] m_axis_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  first_person_camera_update uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam longint DEG90 = 5898240;
  localparam longint DEG180 = 11796480;
  localparam longint DEG360 = 23592960;
  localparam longint PITCH_LIM = 5832704;
  localparam longint Q14_ONE = 16384;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam int WATCHDOG_LIMIT = 5000;

  // atan(2^-i) in degrees with 16 fraction bits
  localparam longint ATAN_DEG [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // camera model state and register copies
  longint cam_pos [3];
  longint cam_yaw, cam_pitch;
  longint cam_front [3], cam_right [3], cam_up [3];
  bit     cam_sprint;
  longint reg_sens, reg_base, reg_sprint_spd;
  longint reg_sx, reg_sy, reg_sz, reg_syaw, reg_spitch;

  cam_view_t expected_views [$];
  int  error_count;
  bit  quiet;
  int  idle_cycles;

  function automatic longint wrap_angle(input longint v);
    longint r;
    r = (v + DEG180) % DEG360;
    if (r < 0) r += DEG360;
    return r - DEG180;
  endfunction

  function automatic longint clamp_lim(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void cordic_rot(input longint ang, output longint c, output longint s);
    longint x, y, z, xs, ys;
    x = 652032874; y = 0; z = ang;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_DEG[i];
      end else begin
        x += ys; y -= xs; z += ATAN_DEG[i];
      end
    end
    c = x; s = y;
  endfunction

  function automatic longint q30_q14(input longint v);
    return clamp_lim((v + (64'sd1 <<< 15)) >>> 16, Q14_ONE);
  endfunction

  function automatic longint q60_q14(input longint v);
    return clamp_lim((v + (64'sd1 <<< 45)) >>> 46, Q14_ONE);
  endfunction

  function automatic void rebuild_basis();
    longint cy, sy, cp, sp, a;
    bit flip;
    a = cam_yaw; flip = 0;
    // fold yaw into the cordic range
    if (a > DEG90) begin
      a -= DEG180; flip = 1;
    end else if (a < -DEG90) begin
      a += DEG180; flip = 1;
    end
    cordic_rot(a, cy, sy);
    if (flip) begin
      cy = -cy; sy = -sy;
    end
    cordic_rot(cam_pitch, cp, sp);
    cam_front[0] = q60_q14(cy * cp);
    cam_front[1] = q30_q14(sp);
    cam_front[2] = q60_q14(sy * cp);
    cam_right[0] = q30_q14(-sy);
    cam_right[1] = 0;
    cam_right[2] = q30_q14(cy);
    cam_up[0] = q60_q14(-cy * sp);
    cam_up[1] = q30_q14(cp);
    cam_up[2] = q60_q14(-sy * sp);
  endfunction

  function automatic longint mouse_delta(input longint counts);
    longint p, m, q;
    p = counts * reg_sens;
    m = (p < 0) ? -p : p;
    q = (m + 5) / 10;
    return (p < 0) ? -q : q;
  endfunction

  function automatic void move_camera(input int axis, input bit neg, input longint vel);
    longint c, d;
    for (int k = 0; k < 3; k++) begin
      case (axis)
        0: c = cam_front[k];
        1: c = cam_right[k];
        default: c = cam_up[k];
      endcase
      if (neg) c = -c;
      d = (c * vel + (64'sd1 <<< 21)) >>> 22;
      cam_pos[k] = cam_pos[k] + d;
      if (cam_pos[k] > I32_MAX) cam_pos[k] = I32_MAX;
      if (cam_pos[k] < I32_MIN) cam_pos[k] = I32_MIN;
    end
  endfunction

  function automatic void camera_defaults();
    reg_sens = 6554; reg_base = 1280; reg_sprint_spd = 2560;
    reg_sx = 0; reg_sy = 0; reg_sz = 0; reg_syaw = -DEG90; reg_spitch = 0;
    cam_pos = '{0, 0, 0};
    cam_yaw = -DEG90; cam_pitch = 0;
    cam_front = '{0, 0, -Q14_ONE};
    cam_right = '{Q14_ONE, 0, 0};
    cam_up = '{0, Q14_ONE, 0};
    cam_sprint = 0;
  endfunction

  function automatic cam_view_t predict_view(input cmd_t cmd, input logic [55:0] d);
    cam_view_t v;
    longint vel;
    case (cmd)
      CMD_MOUSE: begin
        cam_yaw = wrap_angle(cam_yaw + mouse_delta(longint'($signed(d[15:0]))));
        cam_pitch = clamp_lim(cam_pitch + mouse_delta(longint'($signed(d[31:16]))),
                              PITCH_LIM);
        rebuild_basis();
      end
      CMD_TICK: begin
        vel = (cam_sprint ? reg_sprint_spd : reg_base) * longint'(d[47:32]);
        if (d[48]) move_camera(0, 0, vel);
        if (d[49]) move_camera(1, 1, vel);
        if (d[50]) move_camera(0, 1, vel);
        if (d[51]) move_camera(1, 0, vel);
        if (d[52]) move_camera(2, 0, vel);
        if (d[53]) move_camera(2, 1, vel);
        cam_sprint = d[54];
      end
      CMD_RESTART: begin
        cam_pos[0] = reg_sx; cam_pos[1] = reg_sy; cam_pos[2] = reg_sz;
        cam_yaw = wrap_angle(reg_syaw);
        cam_pitch = clamp_lim(reg_spitch, PITCH_LIM);
        rebuild_basis();
      end
      default: ;
    endcase
    v.px = cam_pos[0][31:0]; v.py = cam_pos[1][31:0]; v.pz = cam_pos[2][31:0];
    v.fx = cam_front[0][15:0]; v.fy = cam_front[1][15:0]; v.fz = cam_front[2][15:0];
    v.yaw = cam_yaw[24:0]; v.pitch = cam_pitch[23:0];
    return v;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // receiver stalls
  always @(negedge clk)
    m_axis_tready <= quiet || ($urandom_range(99) >= 24);

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    cam_view_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none actual %h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        e = expected_views.pop_front();
        check_field("pos_x", e.px, m_axis_tdata[31:0]);
        check_field("pos_y", e.py, m_axis_tdata[63:32]);
        check_field("pos_z", e.pz, m_axis_tdata[95:64]);
        check_field("front_x", e.fx, m_axis_tdata[111:96]);
        check_field("front_y", e.fy, m_axis_tdata[127:112]);
        check_field("front_z", e.fz, m_axis_tdata[143:128]);
        check_field("yaw_out", e.yaw, m_axis_tdata[168:144]);
        check_field("pitch_out", e.pitch, m_axis_tdata[192:169]);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (s_axis_tvalid || expected_views.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input cmd_t cmd, input logic [15:0] dx, input logic [15:0] dy,
                           input logic [15:0] dt, input logic [6:0] keys);
    while (!quiet && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {1'b0, keys, dt, dy, dx};
    do @(posedge clk); while (!s_axis_tready);
    expected_views.push_back(predict_view(cmd, {1'b0, keys, dt, dy, dx}));
    @(negedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 0;
    while (expected_views.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    case (idx)
      REG_SENS: reg_sens = val[15:0];
      REG_BASE_SPEED: reg_base = val[15:0];
      REG_SPRINT_SPEED: reg_sprint_spd = val[15:0];
      REG_START_X: reg_sx = longint'($signed(val));
      REG_START_Y: reg_sy = longint'($signed(val));
      REG_START_Z: reg_sz = longint'($signed(val));
      REG_START_YAW: reg_syaw = longint'($signed(val[24:0]));
      default: reg_spitch = longint'($signed(val[23:0]));
    endcase
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic send_random_item();
    int r;
    logic [15:0] dx, dy;
    r = $urandom_range(99);
    if ($urandom_range(1)) begin
      dx = 16'($urandom); dy = 16'($urandom);
    end else begin
      dx = 16'($signed($urandom_range(400)) - 200);
      dy = 16'($signed($urandom_range(400)) - 200);
    end
    if (r < 40) send_item(CMD_MOUSE, dx, dy, 16'($urandom), 7'($urandom));
    else if (r < 82) send_item(CMD_TICK, dx, dy, 16'($urandom), 7'($urandom));
    else if (r < 93) send_item(CMD_RESTART, dx, dy, 16'($urandom), 7'($urandom));
    else send_item(CMD_NONE, dx, dy, 16'($urandom), 7'($urandom));
  endtask

  task automatic test_defaults_and_turns();
    send_item(CMD_NONE, 16'hffff, 16'hffff, 16'hffff, 7'h7f);
    send_item(CMD_TICK, 0, 0, 16'hffff, 7'b0000001);
    send_item(CMD_MOUSE, 16'h7fff, 0, 0, 0);
    send_item(CMD_MOUSE, 16'h8000, 16'h8000, 0, 0);
    send_item(CMD_MOUSE, 0, 16'h7fff, 0, 0);
    send_item(CMD_MOUSE, 16'd5, 16'hfffb, 0, 0);
    send_item(CMD_MOUSE, 0, 0, 0, 0);
    settle();
  endtask

  task automatic test_movement();
    send_item(CMD_TICK, 0, 0, 16'hffff, 7'b0111111);
    send_item(CMD_TICK, 0, 0, 16'h8000, 7'b1000101);
    send_item(CMD_TICK, 0, 0, 16'h8000, 7'b0001010);
    send_item(CMD_TICK, 0, 0, 16'h0000, 7'b1110000);
    send_item(CMD_TICK, 0, 0, 16'h1234, 7'b0100000);
    send_item(CMD_RESTART, 0, 0, 0, 0);
    settle();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_SENS, 32'hffff);
    write_reg(REG_BASE_SPEED, 32'hffff);
    write_reg(REG_SPRINT_SPEED, 32'h0);
    write_reg(REG_START_X, 32'h7fff0000);
    write_reg(REG_START_Y, 32'h80000000);
    write_reg(REG_START_Z, 32'h7fffffff);
    write_reg(REG_START_YAW, 32'h0ffffff);
    write_reg(REG_START_PITCH, 32'h7fffff);
    send_item(CMD_RESTART, 0, 0, 0, 0);
    send_item(CMD_TICK, 0, 0, 16'hffff, 7'b1111111);
    send_item(CMD_TICK, 0, 0, 16'hffff, 7'b0010101);
    send_item(CMD_MOUSE, 16'h7fff, 16'h8000, 0, 0);
    settle();
    write_reg(REG_SENS, 32'h0);
    write_reg(REG_START_YAW, 32'h1000000);
    write_reg(REG_START_PITCH, 32'h800000);
    write_reg(REG_START_X, 32'h80000000);
    send_item(CMD_MOUSE, 16'h7fff, 16'h7fff, 0, 0);
    send_item(CMD_RESTART, 0, 0, 0, 0);
    send_item(CMD_TICK, 0, 0, 16'hffff, 7'b1001010);
    settle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_SENS, (phase == 3) ? 32'hffff : $urandom_range(20000));
      write_reg(REG_BASE_SPEED, $urandom);
      write_reg(REG_SPRINT_SPEED, (phase == 0) ? 32'hffff : $urandom);
      write_reg(REG_START_X, $urandom);
      write_reg(REG_START_Y, (phase == 1) ? 32'h7fffffff : $urandom);
      write_reg(REG_START_Z, $urandom);
      write_reg(REG_START_YAW, $urandom);
      write_reg(REG_START_PITCH, $urandom);
      // one phase without any gaps or stalls
      quiet = (phase == 2);
      repeat (100) send_random_item();
      settle();
      quiet = 0;
    end
  endtask

  initial begin
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = CMD_NONE;
    m_axis_tready = 0;
    cfg_we = 0; cfg_index = REG_SENS; cfg_data = '0;
    error_count = 0; quiet = 0; idle_cycles = 0;
    camera_defaults();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    test_defaults_and_turns();
    test_movement();
    test_register_extremes();
    test_random_traffic();
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
